/* rtl/core/cic_mass_assignment_weights_core_defines.svh */
// assertion macros shared by the cloud-in-cell weight core
// no dependencies; included by files that carry concurrent checks
`ifndef CIC_MASS_ASSIGNMENT_WEIGHTS_CORE_DEFINES_SVH
`define CIC_MASS_ASSIGNMENT_WEIGHTS_CORE_DEFINES_SVH

// same-cycle implication, checks suspended during reset
`define CMAW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checks suspended during reset
`define CMAW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/cmaw_pkg.sv */
// shared constants and helpers for the cloud-in-cell weight core
// no dependencies
package cmaw_pkg;

  localparam logic [15:0] HALF_Q16  = 16'd32768;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [51:0] ROUND_W   = 52'h0_0000_8000_0000;
  localparam logic [2:0]  LAST_CORNER = 3'd7;

  typedef enum logic [2:0] {
    REG_GRID_NX  = 3'd0,
    REG_GRID_NY  = 3'd1,
    REG_GRID_NZ  = 3'd2,
    REG_INV_X    = 3'd3,
    REG_INV_Y    = 3'd4,
    REG_INV_Z    = 3'd5
  } cfg_reg_t;

  // shifted-axis mask per corner code: bit0 x, bit1 y, bit2 z
  function automatic logic [2:0] corner_axes(input logic [2:0] corner);
    logic [2:0] m;
    case (corner)
      3'd0:    m = 3'b000;
      3'd1:    m = 3'b001;
      3'd2:    m = 3'b010;
      3'd3:    m = 3'b100;
      3'd4:    m = 3'b011;
      3'd5:    m = 3'b101;
      3'd6:    m = 3'b110;
      3'd7:    m = 3'b111;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/cmaw_axis.sv */
// per-axis cell locator: home cell, wrapped neighbour, distance and range check
// depends on cmaw_pkg
module cmaw_axis import cmaw_pkg::*; #(
  parameter int GRID_BITS = 10
) (
  input  logic [39:0]          g_hi,   // grid coordinate, bits 63..24 of the product
  input  logic [GRID_BITS:0]   n,      // effective cell count
  output logic [GRID_BITS-1:0] home,
  output logic [GRID_BITS-1:0] nbr,
  output logic [15:0]          dr,
  output logic                 ok
);

  logic [23:0]          cell_no;
  logic [15:0]          f;
  logic                 up;
  logic                 down;
  logic [GRID_BITS:0]   home_inc;

  assign cell_no = g_hi[39:16];
  assign f       = g_hi[15:0];
  assign ok      = cell_no < 24'(n);
  assign home    = cell_no[GRID_BITS-1:0];

  always_comb begin
    if (f >= HALF_Q16) begin
      dr   = f - HALF_Q16;
      up   = (f != HALF_Q16);
      down = 1'b0;
    end else begin
      dr   = HALF_Q16 - f;
      up   = 1'b0;
      down = 1'b1;
    end
  end

  assign home_inc = {1'b0, home} + (GRID_BITS+1)'(1);

  always_comb begin
    if (up) begin
      nbr = (home_inc == n) ? '0 : home_inc[GRID_BITS-1:0];
    end else if (down) begin
      nbr = (home == '0) ? GRID_BITS'(n - (GRID_BITS+1)'(1)) : home - GRID_BITS'(1);
    end else begin
      nbr = home;
    end
  end

endmodule

/* rtl/core/cic_mass_assignment_weights_core.sv */
// top level of the 3-d cloud-in-cell mass assignment weight core
// depends on cmaw_pkg, cmaw_axis and cic_mass_assignment_weights_core_defines.svh
//
// usage
// - input channel (in_valid/in_ready): one particle per transfer, pos_x/y/z in
//   unsigned q16.16 length units
// - config channel (cfg_valid/cfg_ready): cfg_index picks grid_nx, grid_ny,
//   grid_nz, inv_cell_x, inv_cell_y, inv_cell_z (indexes 0..5), others are
//   dropped; write only while the core is idle; cfg_ready is always high
// - output channel (out_valid/out_ready): eight transfers per particle in
//   corner order 0..7, last set on the eighth; out_of_range particles still
//   give eight transfers with cell_index and weight zero
// - flow: after the input transfer the first result passes the f1, f2,
//   expander, b1, b2, b3 and output registers; the rest follow one per cycle
//   while out_ready is high; the single result channel drains the corner
//   expander; a new particle is taken while the previous one is still
//   expanding or in flight
// - stalls: low out_ready holds every stage in place, valid bits move with the
//   data, nothing is dropped or repeated; in_ready falls once the stages fill
// - reset: pipeline empties, registers return to 256 cells and 1.0 per axis
module cic_mass_assignment_weights_core import cmaw_pkg::*; #(
  parameter int GRID_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // particle channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] cell_index,
  output logic [16:0] weight,
  output logic [2:0]  corner,
  output logic        last,
  output logic        out_of_range
);

`include "cic_mass_assignment_weights_core_defines.svh"

  localparam int GB   = GRID_BITS;
  localparam int NW   = GB + 1;        // effective cell count width
  localparam int NYXW = 2 * GB + 1;    // ny * x
  localparam int IDXW = 3 * GB + 2;    // full flat index product
  localparam logic [10:0] TOP_N = 11'(1) << GB;

  // ---------------------------------------------------------------- config
  logic [10:0] grid_nx, grid_ny, grid_nz;
  logic [31:0] inv_cell_x, inv_cell_y, inv_cell_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_nx    <= 11'd256;
      grid_ny    <= 11'd256;
      grid_nz    <= 11'd256;
      inv_cell_x <= 32'd16777216;
      inv_cell_y <= 32'd16777216;
      inv_cell_z <= 32'd16777216;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_NX: grid_nx    <= cfg_data[10:0];
        REG_GRID_NY: grid_ny    <= cfg_data[10:0];
        REG_GRID_NZ: grid_nz    <= cfg_data[10:0];
        REG_INV_X:   inv_cell_x <= cfg_data;
        REG_INV_Y:   inv_cell_y <= cfg_data;
        REG_INV_Z:   inv_cell_z <= cfg_data;
        default:     ;
      endcase
    end
  end

  // zero counts as one cell, anything beyond the grid limit clamps to it
  function automatic logic [NW-1:0] eff_size(input logic [10:0] n);
    logic [NW-1:0] r;
    if (n == 11'd0) begin
      r = NW'(1);
    end else if (n > TOP_N) begin
      r = NW'(TOP_N);
    end else begin
      r = NW'(n);
    end
    return r;
  endfunction

  logic [NW-1:0] nx, ny, nz;
  assign nx = eff_size(grid_nx);
  assign ny = eff_size(grid_ny);
  assign nz = eff_size(grid_nz);

  // ---------------------------------------------------------- stall chain
  logic en_f1, en_f2, e_load, en_b1, en_b2, en_b3, en_o;
  logic v_f1, v_f2, e_valid, v_b1, v_b2, v_b3;
  logic [2:0] k;
  logic e_done;

  assign en_o   = !out_valid || out_ready;
  assign en_b3  = !v_b3 || en_o;
  assign en_b2  = !v_b2 || en_b3;
  assign en_b1  = !v_b1 || en_b2;
  assign e_done = e_valid && en_b1 && (k == LAST_CORNER);
  assign e_load = !e_valid || e_done;
  assign en_f2  = !v_f2 || e_load;
  assign en_f1  = !v_f1 || en_f2;
  assign in_ready = en_f1;

  // ------------------------------------------------ f1: input register
  logic [31:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f1 <= 1'b0;
    end else if (en_f1) begin
      v_f1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f1 && in_valid) begin
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
    end
  end

  // ------------------------------------- f2: scaled coordinates, q24.40
  logic [63:0] gx_full, gy_full, gz_full;
  logic [39:0] gx, gy, gz;

  assign gx_full = 64'(px) * 64'(inv_cell_x);
  assign gy_full = 64'(py) * 64'(inv_cell_y);
  assign gz_full = 64'(pz) * 64'(inv_cell_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f2 <= 1'b0;
    end else if (en_f2) begin
      v_f2 <= v_f1;
    end
  end

  // fraction bits below 24 are dropped here
  always_ff @(posedge clk) begin
    if (en_f2 && v_f1) begin
      gx <= gx_full[63:24];
      gy <= gy_full[63:24];
      gz <= gz_full[63:24];
    end
  end

  // ------------------------------------ cell location per axis
  logic [GB-1:0] hx_c, hy_c, hz_c, bx_c, by_c, bz_c;
  logic [15:0]   dx_c, dy_c, dz_c;
  logic          okx, oky, okz;

  cmaw_axis #(.GRID_BITS(GB)) u_axis_x (
    .g_hi(gx), .n(nx), .home(hx_c), .nbr(bx_c), .dr(dx_c), .ok(okx)
  );
  cmaw_axis #(.GRID_BITS(GB)) u_axis_y (
    .g_hi(gy), .n(ny), .home(hy_c), .nbr(by_c), .dr(dy_c), .ok(oky)
  );
  cmaw_axis #(.GRID_BITS(GB)) u_axis_z (
    .g_hi(gz), .n(nz), .home(hz_c), .nbr(bz_c), .dr(dz_c), .ok(okz)
  );

  // ------------------------------------ corner expander, holds one particle
  logic [GB-1:0] hx, hy, hz, bx, by, bz;
  logic [15:0]   dx, dy, dz;
  logic          p_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      k       <= '0;
    end else if (e_load) begin
      e_valid <= v_f2;
      k       <= '0;
    end else if (e_valid && en_b1) begin
      k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (e_load && v_f2) begin
      hx   <= hx_c;
      hy   <= hy_c;
      hz   <= hz_c;
      bx   <= bx_c;
      by   <= by_c;
      bz   <= bz_c;
      dx   <= dx_c;
      dy   <= dy_c;
      dz   <= dz_c;
      p_ok <= okx && oky && okz;
    end
  end

  // ------------------------------------ b1: corner select
  logic [2:0]    m;
  logic [GB-1:0] x1, y1, z1;
  logic [16:0]   fx1, fy1, fz1;
  logic [2:0]    c1;
  logic          last1, oor1;

  assign m = corner_axes(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b1 <= 1'b0;
    end else if (en_b1) begin
      v_b1 <= e_valid;
    end
  end

  // out-of-range particles run through with zero cells and factors
  always_ff @(posedge clk) begin
    if (en_b1 && e_valid) begin
      c1    <= k;
      last1 <= (k == LAST_CORNER);
      oor1  <= !p_ok;
      if (p_ok) begin
        x1  <= m[0] ? bx : hx;
        y1  <= m[1] ? by : hy;
        z1  <= m[2] ? bz : hz;
        fx1 <= m[0] ? 17'(dx) : ONE_Q16 - 17'(dx);
        fy1 <= m[1] ? 17'(dy) : ONE_Q16 - 17'(dy);
        fz1 <= m[2] ? 17'(dz) : ONE_Q16 - 17'(dz);
      end else begin
        x1  <= '0;
        y1  <= '0;
        z1  <= '0;
        fx1 <= '0;
        fy1 <= '0;
        fz1 <= '0;
      end
    end
  end

  // ------------------------------------ b2: ny*x and fx*fy
  logic [NYXW-1:0] nyx2;
  logic [33:0]     fxy2;
  logic [GB-1:0]   y2, z2;
  logic [16:0]     fz2;
  logic [2:0]      c2;
  logic            last2, oor2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b2 <= 1'b0;
    end else if (en_b2) begin
      v_b2 <= v_b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b2 && v_b1) begin
      nyx2  <= NYXW'(ny) * NYXW'(x1);
      fxy2  <= 34'(fx1) * 34'(fy1);
      y2    <= y1;
      z2    <= z1;
      fz2   <= fz1;
      c2    <= c1;
      last2 <= last1;
      oor2  <= oor1;
    end
  end

  // ------------------------------------ b3: nz*(y + ny*x) and fxy*fz
  logic [NYXW-1:0] yx_sum;
  logic [IDXW-1:0] prod3;
  logic [50:0]     fxyz3;
  logic [GB-1:0]   z3;
  logic [2:0]      c3;
  logic            last3, oor3;

  assign yx_sum = NYXW'(y2) + nyx2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b3 <= 1'b0;
    end else if (en_b3) begin
      v_b3 <= v_b2;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b3 && v_b2) begin
      prod3 <= IDXW'(yx_sum) * IDXW'(nz);
      fxyz3 <= 51'(fxy2) * 51'(fz2);
      z3    <= z2;
      c3    <= c2;
      last3 <= last2;
      oor3  <= oor2;
    end
  end

  // ------------------------------------ output register
  logic [IDXW-1:0] idx_full;
  logic [51:0]     w_sum;

  assign idx_full = IDXW'(z3) + prod3;
  assign w_sum    = 52'(fxyz3) + ROUND_W;   // round half up, then drop 32 bits

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= v_b3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && v_b3) begin
      cell_index   <= 30'(idx_full);
      weight       <= w_sum[48:32];
      corner       <= c3;
      last         <= last3;
      out_of_range <= oor3;
    end
  end

  // ------------------------------------ checks
  `CMAW_ASSERT_NOW(a_oor_zero, clk, rst, out_valid && out_of_range,
    (cell_index == 30'd0) && (weight == 17'd0), "out-of-range result carries data")
  `CMAW_ASSERT_NOW(a_weight_max, clk, rst, out_valid, weight <= ONE_Q16,
    "weight above one")
  `CMAW_ASSERT_NOW(a_last_corner, clk, rst, out_valid, last == (corner == LAST_CORNER),
    "last flag out of step with corner")
  `CMAW_ASSERT_NEXT(a_corner_step, clk, rst, e_valid && en_b1 && (k != LAST_CORNER),
    e_valid && (k == $past(k) + 3'd1), "expander skipped or repeated a corner")
  `CMAW_ASSERT_NEXT(a_new_particle, clk, rst, e_load && v_f2,
    e_valid && (k == 3'd0), "new particle did not start at corner zero")

endmodule

/* test/tb.sv */
// self-checking bench for cic_mass_assignment_weights_core: directed probes, then random particles
// checks all eight corner transfers of each particle against probe expectations or an in-bench stencil calculation
// depends on cmaw_pkg and the core rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmaw_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_ITEMS  = 20;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned HOLD_AFTER   = 40;   // particle count that arms the long output hold
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned REPORT_MAX   = 10;

  // register indexes the core drops
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // shifted axes per corner code, bit0 x, bit1 y, bit2 z: none, x, y, z, xy, xz, yz, xyz
  localparam logic [2:0] SHIFTED_AXES [8] = '{3'b000, 3'b001, 3'b010, 3'b100,
                                              3'b011, 3'b101, 3'b110, 3'b111};

  typedef struct packed {
    logic [29:0] cell_index;
    logic [16:0] weight;
    logic [2:0]  corner;
    logic        last;
    logic        out_of_range;
  } corner_result_t;

  // directed probe: a position plus, where obvious, the expected home index and corner-0 weight
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        typed;
    logic [29:0] idx;
    logic [16:0] w0;
    logic        oor;
  } probe_t;

  // all probes run with the reset grid: 256 cells per axis, one cell per length unit
  localparam probe_t PROBES [16] = '{
    // exact centre of cell 0, zero offset on every axis
    '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b1, 30'd0, 17'd65536, 1'b0},
    // exact centre of the top cell
    '{32'h00FF_8000, 32'h00FF_8000, 32'h00FF_8000, 1'b1, 30'd16777215, 17'd65536, 1'b0},
    // centre of cell (128, 1, 0)
    '{32'h0080_8000, 32'h0001_8000, 32'h0000_8000, 1'b1, 30'd8388864, 17'd65536, 1'b0},
    // origin, neighbour wraps to the top cell on every axis
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 30'd0, 17'd0, 1'b0},
    // just below N, neighbour wraps to cell 0
    '{32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 1'b0, 30'd0, 17'd0, 1'b0},
    // coordinate exactly N on one axis
    '{32'h0100_0000, 32'h0000_8000, 32'h0000_8000, 1'b1, 30'd0, 17'd0, 1'b1},
    '{32'h0000_8000, 32'h0100_0000, 32'h0000_8000, 1'b1, 30'd0, 17'd0, 1'b1},
    '{32'h0000_8000, 32'h0000_8000, 32'h0100_0000, 1'b1, 30'd0, 17'd0, 1'b1},
    // all ones
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 30'd0, 17'd0, 1'b1},
    // one lsb either side of the centre
    '{32'h0000_8001, 32'h0000_7FFF, 32'h0080_8000, 1'b0, 30'd0, 17'd0, 1'b0},
    '{32'h0001_0000, 32'h00FF_0000, 32'h007F_FFFF, 1'b0, 30'd0, 17'd0, 1'b0},
    '{32'h0012_3456, 32'h00AB_CDEF, 32'h0055_AA55, 1'b0, 30'd0, 17'd0, 1'b0},
    '{32'h00FF_FFFF, 32'h0000_0000, 32'h0080_C000, 1'b0, 30'd0, 17'd0, 1'b0},
    // one lsb past N on z
    '{32'h0000_4000, 32'h00FF_C000, 32'h0100_0001, 1'b1, 30'd0, 17'd0, 1'b1},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0033_3333, 1'b1, 30'd0, 17'd0, 1'b1},
    '{32'h5555_5555, 32'h00AA_AAAA, 32'hFFFF_0000, 1'b1, 30'd0, 17'd0, 1'b1}
  };

  // dut ports, every input known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [31:0] pos_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [29:0] cell_index;
  logic [16:0] weight;
  logic [2:0]  corner;
  logic        last;
  logic        out_of_range;

  // shadow copy of the grid registers, reset values
  logic [10:0] cells_x = 11'd256;
  logic [10:0] cells_y = 11'd256;
  logic [10:0] cells_z = 11'd256;
  logic [31:0] scale_x = 32'h0100_0000;
  logic [31:0] scale_y = 32'h0100_0000;
  logic [31:0] scale_z = 32'h0100_0000;

  corner_result_t pending_corners [$];
  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;
  int unsigned    particles_taken = 0;

  // output-side stall state
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_left = 0;
  int unsigned window_count = 0;
  bit          drain_fast = 1'b0;

  cic_mass_assignment_weights_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_index   (cell_index),
    .weight       (weight),
    .corner       (corner),
    .last         (last),
    .out_of_range (out_of_range)
  );

  always #6 clk = ~clk;

  // append one expected transfer at the tail of the queue
  function automatic void queue_corner(input corner_result_t r);
    pending_corners = {pending_corners, r};
  endfunction

  // grid size as the core uses it: zero reads as one, anything past 2^10 as 2^10
  function automatic logic [10:0] clamp_cells(input logic [10:0] n);
    if (n == 11'd0) return 11'd1;
    if (n > 11'd1024) return 11'd1024;
    return n;
  endfunction

  // one axis: home cell, neighbour cell on the side of the offset, and |offset| in q0.16
  function automatic void locate_axis(input logic [31:0] pos, input logic [31:0] inv,
                                      input logic [10:0] n, output logic in_grid,
                                      output logic [10:0] home, output logic [10:0] nbr,
                                      output logic [16:0] near_frac);
    logic [63:0] g;
    logic [23:0] cell_no;
    logic [15:0] f;
    g = {32'd0, pos} * {32'd0, inv};
    cell_no = g[63:40];
    f = g[39:24];
    in_grid = (cell_no < {13'd0, n});
    home = cell_no[10:0];
    if (f >= HALF_Q16) begin
      near_frac = {1'b0, f - HALF_Q16};
      // zero offset: neighbour is the home cell with zero factor
      if (near_frac != 17'd0) nbr = (home + 11'd1 == n) ? 11'd0 : home + 11'd1;
      else nbr = home;
    end else begin
      near_frac = {1'b0, HALF_Q16 - f};
      nbr = (home == 11'd0) ? n - 11'd1 : home - 11'd1;
    end
  endfunction

  // queue the eight corner transfers one particle should produce under the current grid
  task automatic predict_stencil(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] pz);
    logic [10:0] nx, ny, nz, hx, hy, hz, bx, by, bz;
    logic [16:0] dx, dy, dz;
    logic        okx, oky, okz;
    logic [2:0]  m;
    logic [63:0] fx, fy, fz, idx, prod;
    corner_result_t r;
    nx = clamp_cells(cells_x);
    ny = clamp_cells(cells_y);
    nz = clamp_cells(cells_z);
    locate_axis(px, scale_x, nx, okx, hx, bx, dx);
    locate_axis(py, scale_y, ny, oky, hy, by, dy);
    locate_axis(pz, scale_z, nz, okz, hz, bz, dz);
    for (int k = 0; k < 8; k++) begin
      m = SHIFTED_AXES[k];
      r.corner = 3'(k);
      r.last = (3'(k) == LAST_CORNER);
      r.out_of_range = !(okx && oky && okz);
      r.cell_index = '0;
      r.weight = '0;
      if (okx && oky && okz) begin
        fx = m[0] ? 64'(dx) : 64'(ONE_Q16 - dx);
        fy = m[1] ? 64'(dy) : 64'(ONE_Q16 - dy);
        fz = m[2] ? 64'(dz) : 64'(ONE_Q16 - dz);
        idx = 64'(m[2] ? bz : hz) +
              64'(nz) * (64'(m[1] ? by : hy) + 64'(ny) * 64'(m[0] ? bx : hx));
        prod = fx * fy * fz;
        r.cell_index = idx[29:0];
        r.weight = 17'((prod + 64'h8000_0000) >> 32);
      end
      queue_corner(r);
    end
  endtask

  // random coordinate that mostly lands inside the grid, sometimes near or past its edge
  function automatic logic [31:0] pick_position(input logic [10:0] n, input logic [31:0] inv);
    logic [63:0] span;
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (inv == 32'd0) span = 64'hFFFF_FFFF;
    else span = ({53'd0, n} << 40) / {32'd0, inv};
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    if (sel < 2) return $urandom();
    if (sel == 2) return span[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
    return $urandom_range(0, span[31:0]);
  endfunction

  // one register transfer, shadow updated when it is taken
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRID_NX: cells_x = data[10:0];
      REG_GRID_NY: cells_y = data[10:0];
      REG_GRID_NZ: cells_z = data[10:0];
      REG_INV_X:   scale_x = data;
      REG_INV_Y:   scale_y = data;
      REG_INV_Z:   scale_z = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // grid setting per phase: fixed extremes in phases 0, 1 and 3, random settings in the others
  task automatic apply_setting(input int unsigned ph);
    logic [31:0] v [6];
    case (ph)
      // largest x grid at full scale, y size zero with zero scale, z size past 1024
      0: v = '{32'd1024, 32'd0, 32'h0000_07FF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001};
      1: v = '{32'd1, 32'd1024, 32'd3, 32'h0100_0000, 32'h0040_0000, 32'h0400_0000};
      // upper data bits above the 11-bit size are dropped
      3: v = '{32'hFFFF_F811, 32'd1000, 32'd64, 32'h00A0_0000, 32'h1234_5678, 32'h0001_0000};
      default: begin
        for (int r = 0; r < 3; r++)
          v[r] = ($urandom() & 32'hFFFF_F800) | 32'($urandom_range(1, 1024));
        for (int r = 3; r < 6; r++) v[r] = $urandom();
      end
    endcase
    write_reg(REG_GRID_NX, v[0]);
    write_reg(REG_GRID_NY, v[1]);
    write_reg(REG_GRID_NZ, v[2]);
    write_reg(REG_INV_X, v[3]);
    write_reg(REG_INV_Y, v[4]);
    write_reg(REG_INV_Z, v[5]);
    if (ph == 0) begin
      // indexes past the register list must leave the grid alone
      write_reg(REG_SPARE_6, $urandom());
      write_reg(REG_SPARE_7, $urandom());
    end
  endtask

  // offer one particle, hold it until taken, then maybe idle for a while
  task automatic send_particle(input probe_t p, input bit burst);
    int unsigned gap, roll;
    @(negedge clk);
    in_valid <= 1'b1;
    pos_x <= p.px;
    pos_y <= p.py;
    pos_z <= p.pz;
    do @(posedge clk); while (!in_ready);
    particles_taken++;
    if (p.typed) begin
      // expectation read straight off the probe: one home index, weight only on corner 0
      for (int k = 0; k < 8; k++)
        queue_corner(corner_result_t'{p.oor ? 30'd0 : p.idx, (k == 0) ? p.w0 : 17'd0,
                                      3'(k), 3'(k) == LAST_CORNER, p.oor});
    end else begin
      predict_stencil(p.px, p.py, p.pz);
    end
    roll = $urandom_range(0, 99);
    if (burst || roll < 45) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // main sequence
  initial begin
    probe_t p;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed probes under the reset grid
    foreach (PROBES[i]) send_particle(PROBES[i], 1'b0);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_corners.size() != 0) @(posedge clk);

    // random particles, new grid per phase, core idle at each change
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      apply_setting(ph);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        p.px = pick_position(clamp_cells(cells_x), scale_x);
        p.py = pick_position(clamp_cells(cells_y), scale_y);
        p.pz = pick_position(clamp_cells(cells_z), scale_z);
        p.typed = 1'b0;
        p.idx = '0;
        p.w0 = '0;
        p.oor = 1'b0;
        // phase 1 streams back to back, which is also where the long hold lands
        send_particle(p, ph == 1);
      end
      @(negedge clk);
      in_valid <= 1'b0;
      while (pending_corners.size() != 0) @(posedge clk);
    end

    // trailing cycles to catch stray transfers
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[cic_mass_assignment_weights_core] OK");
    end else begin
      $display("[cic_mass_assignment_weights_core] ERROR");
    end
    $finish;
  end

  // result side backpressure: short and long stalls, free-running windows, one long hold
  always @(negedge clk) begin
    window_count++;
    if (window_count % 64 == 0) drain_fast = ($urandom_range(0, 3) == 0);
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && particles_taken >= HOLD_AFTER) begin
      // input keeps coming while this runs, so the stages fill and in_ready drops
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!drain_fast && $urandom_range(0, 99) < 20)
        stall_left = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    corner_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {cell_index, weight, corner, last, out_of_range};
      if (pending_corners.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected transfer: index %0d weight %0d corner %0d last %0b oor %0b",
                   got.cell_index, got.weight, got.corner, got.last, got.out_of_range);
      end else begin
        want = pending_corners.pop_front();
        if (got !== want) begin
          mismatches++;
          // pairs read expected/actual
          if (mismatches <= REPORT_MAX)
            $display("exp/act idx %0d/%0d w %0d/%0d crn %0d/%0d last %0b/%0b oor %0b/%0b",
                     want.cell_index, got.cell_index, want.weight, got.weight,
                     want.corner, got.corner, want.last, got.last,
                     want.out_of_range, got.out_of_range);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[cic_mass_assignment_weights_core] ERROR");
      $finish;
    end
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/cmaw_pkg.sv
rtl/core/cmaw_axis.sv
rtl/core/cic_mass_assignment_weights_core.sv
test/tb.sv
